// ===== src/rpfr_pkg.sv =====
// Shared types and constants for the reduced-precision float rounder.
package rpfr_pkg;

  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned ReportWidth   = 32;

  localparam logic [10:0] ExpAll    = 11'h7ff;
  localparam int          ExpBias   = 1023;
  localparam int          SigBits   = 53;
  localparam int          FracBits  = 52;
  localparam logic [5:0]  NativePrec = 6'd53;
  localparam logic signed [10:0] NativeEmin = -11'sd1022;
  localparam logic signed [10:0] NativeEmax = 11'sd1023;

  typedef enum logic [1:0] {
    ACT_ROUND = 2'd0,
    ACT_CHECK = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    CFG_PRECISION = 2'd0,
    CFG_MIN_EXP   = 2'd1,
    CFG_MAX_EXP   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic on_midpoint;
    logic format_bad;
    logic nonfinite;
    logic not_format;
    logic overflow;
    logic underflow;
  } rpfr_flags_t;

endpackage

// ===== src/rpfr_round.sv =====
// Combinational rounding of one binary64 pattern to the configured format.
module rpfr_round (
  input  logic [1:0]              action_i,
  input  logic [63:0]             value_bits_i,
  input  logic signed [1:0]       tie_direction_i,
  input  logic [5:0]              precision_i,
  input  logic signed [10:0]      min_exponent_i,
  input  logic signed [10:0]      max_exponent_i,
  output logic [63:0]             result_bits_o,
  output rpfr_pkg::rpfr_flags_t   flags_o
);
  import rpfr_pkg::*;

  logic              sign;
  logic [10:0]       ex;
  logic [51:0]       frac;
  logic [63:0]       mag;
  logic signed [12:0] emin, emax, e, extra, sh, e2;
  logic              native, bad;
  logic              sh_zero, sh_mid, sh_top;
  logic [5:0]        sh6;
  logic [63:0]       q, low_mask, low, half, mag_trunc, mag_r;
  logic              odd, up;
  logic              dir_pos, dir_neg, dir_zero, mdir_pos;
  logic              is_nan, is_inf_nan, is_zero;
  logic              mid, r_ovf, r_udf;
  logic [63:0]       r_bits;
  action_e           act;

  assign sign = value_bits_i[63];
  assign ex   = value_bits_i[62:52];
  assign frac = value_bits_i[51:0];
  assign mag  = {1'b0, value_bits_i[62:0]};
  assign act  = action_e'(action_i);

  assign emin = {{2{min_exponent_i[10]}}, min_exponent_i};
  assign emax = {{2{max_exponent_i[10]}}, max_exponent_i};

  assign native = (precision_i == NativePrec) && (min_exponent_i == NativeEmin)
                  && (max_exponent_i == NativeEmax);
  assign bad = (precision_i < 6'd2) || (precision_i > NativePrec) || (emin > emax)
               || (!native && (emin < $signed({7'b0, precision_i}) - 13'sd1021));

  // Position of the rounding point, widened below emin for gradual underflow.
  assign e     = $signed({2'b0, ex}) - 13'(ExpBias);
  assign extra = (e < emin) ? (emin - e) : 13'sd0;
  assign sh    = 13'(SigBits) - $signed({7'b0, precision_i}) + extra;

  assign sh_zero = (sh == 13'sd0);
  assign sh_mid  = (sh > 13'sd0) && (sh <= 13'(FracBits));
  assign sh_top  = (sh == 13'(SigBits));
  assign sh6     = sh[5:0];

  assign q         = 64'd1 << sh6;
  assign low_mask  = q - 64'd1;
  assign low       = mag & low_mask;
  assign half      = q >> 1;
  assign mag_trunc = mag & ~low_mask;

  // Residual direction, mirrored for negative values.
  assign dir_pos  = (tie_direction_i == 2'sd1) && (act == ACT_ROUND);
  assign dir_neg  = tie_direction_i[1] && (act == ACT_ROUND);
  assign dir_zero = !dir_pos && !dir_neg;
  assign mdir_pos = sign ? dir_neg : dir_pos;

  assign odd = (sh6 == 6'(FracBits)) ? 1'b1 : ((mag_trunc & q) != 64'd0);
  assign up  = (low > half) || ((low == half) && (mdir_pos || (dir_zero && odd)));

  always_comb begin
    if (sh_zero) begin
      mag_r = mag;
    end else if (sh_mid) begin
      mag_r = up ? (mag_trunc + q) : mag_trunc;
    end else if (sh_top) begin
      mag_r = ((frac != 52'd0) || mdir_pos) ? {1'b0, ex + 11'd1, 52'd0} : 64'd0;
    end else begin
      mag_r = 64'd0;
    end
  end

  assign e2 = $signed({2'b0, mag_r[62:52]}) - 13'(ExpBias);

  assign is_inf_nan = (ex == ExpAll);
  assign is_nan     = is_inf_nan && (frac != 52'd0);
  assign is_zero    = (mag == 64'd0);

  always_comb begin
    r_bits = value_bits_i;
    r_ovf  = 1'b0;
    r_udf  = 1'b0;
    if (is_inf_nan || is_zero) begin
      r_bits = value_bits_i;
    end else if (native) begin
      r_udf = (ex == 11'd0);
    end else if (ex == 11'd0) begin
      r_udf  = 1'b1;
      r_bits = {sign, 63'd0};
    end else if (mag_r == 64'd0) begin
      r_udf  = 1'b1;
      r_bits = {sign, 63'd0};
    end else if (e2 > emax) begin
      r_ovf  = 1'b1;
      r_bits = {sign, ExpAll, 52'd0};
    end else begin
      r_udf  = (e2 < emin);
      r_bits = {sign, mag_r[62:0]};
    end
  end

  assign mid = !native && (ex != 11'd0) && !is_inf_nan
               && ((sh_mid && (low == half)) || (sh_top && (frac == 52'd0)));

  always_comb begin
    result_bits_o = 64'd0;
    flags_o       = '0;
    flags_o.format_bad = bad;
    case (act)
      ACT_ROUND, ACT_CHECK: begin
        result_bits_o = value_bits_i;
        if (!bad) begin
          flags_o.on_midpoint = mid;
          flags_o.nonfinite   = is_inf_nan;
          flags_o.overflow    = r_ovf;
          flags_o.underflow   = r_udf;
          if (act == ACT_ROUND) begin
            result_bits_o = r_bits;
          end else begin
            flags_o.not_format = !is_nan && (r_bits != value_bits_i);
          end
        end
      end
      default: begin
        result_bits_o = 64'd0;
      end
    endcase
  end

endmodule

// ===== src/reduced_precision_float_rounder.sv =====
// Top level of the reduced-precision float rounder: handshake, config and event counters.
//
// Input channel: in_valid_i / in_stall_o with action_i, value_bits_i and
// tie_direction_i. An item transfers when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with the rounded pattern, the
// flags and, on a read action, the four event counts.
// Each item passes an input register, one stage of rounding logic and the
// result register, from which it can transfer out. One item is taken every
// cycle while the input register is free or draining; the counter update
// is the only state carried from item to item.
// A stalled result holds in the result register while the input register
// still takes one more item; the input stalls only when both are full.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i at
// any edge with the enable high; index 0 is precision, 1 the smallest and
// 2 the largest normal exponent. Other indexes are ignored. Writes take
// effect on any item still in the input register and belong in idle periods.
// Reset empties both registers, clears the counters and loads the native
// binary64 format (precision 53, exponents -1022..1023).
// The counters saturate; a read action reports them and clears them.
module reduced_precision_float_rounder #(
  parameter int unsigned CountWidth = rpfr_pkg::CountWidthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [10:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          action_i,
  input  logic [63:0]         value_bits_i,
  input  logic signed [1:0]   tie_direction_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [63:0]         result_bits_o,
  output logic                on_midpoint_o,
  output logic                format_bad_o,
  output logic                nonfinite_flag_o,
  output logic                not_format_flag_o,
  output logic                overflow_flag_o,
  output logic                underflow_flag_o,
  output logic [31:0]         count_nonfinite_o,
  output logic [31:0]         count_not_format_o,
  output logic [31:0]         count_overflow_o,
  output logic [31:0]         count_underflow_o
);
  import rpfr_pkg::*;

  localparam logic [CountWidth-1:0] ReportMax = CountWidth'(64'h0000_0000_ffff_ffff);

  logic [5:0]         precision_q;
  logic signed [10:0] min_exp_q, max_exp_q;

  logic               s1_valid_q;
  logic [1:0]         s1_action_q;
  logic [63:0]        s1_value_q;
  logic signed [1:0]  s1_tie_q;
  logic               s1_adv, in_take, s1_read;

  logic               out_valid_q;
  logic [63:0]        out_bits_q;
  rpfr_flags_t        out_flags_q;
  logic [31:0]        out_count_q [4];

  logic [63:0]        rnd_bits;
  rpfr_flags_t        rnd_flags;
  logic [3:0]         events;
  logic [CountWidth-1:0] cnt_q [4];
  logic [CountWidth-1:0] cnt_d [4];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      precision_q <= NativePrec;
      min_exp_q   <= NativeEmin;
      max_exp_q   <= NativeEmax;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PRECISION: precision_q <= cfg_wdata_i[5:0];
        CFG_MIN_EXP:   min_exp_q   <= $signed(cfg_wdata_i);
        CFG_MAX_EXP:   max_exp_q   <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // Advance into the result register when it is empty or being drained.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_action_q <= action_i;
      s1_value_q  <= value_bits_i;
      s1_tie_q    <= tie_direction_i;
    end
  end

  rpfr_round u_round (
    .action_i        (s1_action_q),
    .value_bits_i    (s1_value_q),
    .tie_direction_i (s1_tie_q),
    .precision_i     (precision_q),
    .min_exponent_i  (min_exp_q),
    .max_exponent_i  (max_exp_q),
    .result_bits_o   (rnd_bits),
    .flags_o         (rnd_flags)
  );

  assign s1_read = (s1_action_q == ACT_READ);
  assign events  = {rnd_flags.nonfinite, rnd_flags.not_format,
                    rnd_flags.overflow, rnd_flags.underflow};

  // Saturating event counters; a read clears them after reporting.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cnt_d[i] = cnt_q[i];
      if (s1_read) begin
        cnt_d[i] = '0;
      end else if (events[3-i] && (cnt_q[i] != '1)) begin
        cnt_d[i] = cnt_q[i] + CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) cnt_q[i] <= '0;
    end else if (s1_adv) begin
      for (int i = 0; i < 4; i++) cnt_q[i] <= cnt_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_bits_q  <= rnd_bits;
      out_flags_q <= rnd_flags;
      for (int i = 0; i < 4; i++) begin
        if (!s1_read) begin
          out_count_q[i] <= 32'd0;
        end else if (cnt_q[i] > ReportMax) begin
          out_count_q[i] <= 32'hffff_ffff;
        end else begin
          out_count_q[i] <= ReportWidth'(cnt_q[i]);
        end
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign result_bits_o      = out_bits_q;
  assign on_midpoint_o      = out_flags_q.on_midpoint;
  assign format_bad_o       = out_flags_q.format_bad;
  assign nonfinite_flag_o   = out_flags_q.nonfinite;
  assign not_format_flag_o  = out_flags_q.not_format;
  assign overflow_flag_o    = out_flags_q.overflow;
  assign underflow_flag_o   = out_flags_q.underflow;
  assign count_nonfinite_o  = out_count_q[0];
  assign count_not_format_o = out_count_q[1];
  assign count_overflow_o   = out_count_q[2];
  assign count_underflow_o  = out_count_q[3];

  a_ovf_udf_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(overflow_flag_o && underflow_flag_o))
    else $error("overflow and underflow raised together");

  a_bad_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && format_bad_o) |-> !(nonfinite_flag_o || overflow_flag_o ||
      underflow_flag_o || not_format_flag_o || on_midpoint_o))
    else $error("event flag raised under an invalid format");

  a_read_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_read) |=> ((cnt_q[0] == '0) && (cnt_q[1] == '0) &&
      (cnt_q[2] == '0) && (cnt_q[3] == '0)))
    else $error("counters not cleared by read");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_flags_q)))
    else $error("stalled result lost");

endmodule
